FILE: sv/wdst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdst_pkg
// shared widths, item codes and constants of the watchdog slot table
// ----------------------------------------------------------------------------
package wdst_pkg;

  // slot table size
  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int OP_W        = 2;
  localparam int DUR_W       = 32;
  localparam int IDX_W       = 4;
  localparam int GIVEN_W     = 3;
  localparam int DIV_W       = 24;
  localparam int NOW_W       = 63;
  localparam int DEADLINE_W  = 64;

  // item codes
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

  // saturation limit of the millisecond clock and of deadlines
  localparam logic [NOW_W-1:0]      NOW_MAX      = {NOW_W{1'b1}};
  localparam logic [DEADLINE_W-1:0] DEADLINE_MAX = {1'b0, {NOW_W{1'b1}}};

  // divide value after reset
  localparam logic [DIV_W-1:0] DIV_RESET = 24'd125000;

endpackage

FILE: sv/watchdog_slot_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchdog_slot_table_top
// multi-slot watchdog table with a prescaled millisecond clock
// ----------------------------------------------------------------------------
// Usage: every item returns exactly one result, in order. An item is
// taken into an input register, and from there all of its work
// (lowest free slot search, deadline add with saturation, eight parallel
// deadline compares, prescaler step) is done in one pass into the result
// register. Throughput is one item per clock while the output is not
// stalled; out_valid marks the item once it has passed from the input
// register into the result register. Throughput is
// set by that single pass: state written by one item is seen by the very
// next one. set and check see the millisecond count as it stood before the
// item. A tick returns an all-zero result. cycles_per_ms is to be written
// over the cfg channel (cfg_ready is high out of reset) while the block is
// idle, which the block itself does not enforce; a value of zero behaves like one.
// The millisecond count and all deadlines saturate at 2^63-1; a negative duration yields a deadline in
// the past. Clears with slot_index at or beyond the slot count are ignored.
module watchdog_slot_table_top (
  input  logic                                clk,
  input  logic                                rst,
  // item input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wdst_pkg::OP_W-1:0]           op,
  input  logic signed [wdst_pkg::DUR_W-1:0]   duration_ms,
  input  logic [wdst_pkg::IDX_W-1:0]          slot_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                set_ok,
  output logic [wdst_pkg::GIVEN_W-1:0]        slot_given,
  output logic                                expired,
  // divide value write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wdst_pkg::DIV_W-1:0]          cycles_per_ms
);
  import wdst_pkg::*;

  // input register
  logic                   in_q_valid;
  logic [OP_W-1:0]        op_q;
  logic [DUR_W-1:0]       dur_q;
  logic [IDX_W-1:0]       idx_q;

  // block state
  logic [DIV_W-1:0]       div_value;
  logic [SLOT_COUNT-1:0]  slot_active;
  logic [DEADLINE_W-1:0]  slot_deadline [SLOT_COUNT];
  logic [NOW_W-1:0]       now_ms;
  logic [DIV_W-1:0]       prescale_count;

  // handshake
  logic out_free;
  logic advance;
  logic in_accept;

  // single pass logic
  logic                   found;
  logic [SLOT_COUNT-1:0]  grant;
  logic [SLOT_IDX_W-1:0]  grant_idx;
  logic [DEADLINE_W-1:0]  now_ext;
  logic [DEADLINE_W-1:0]  dur_sum;
  logic [DEADLINE_W-1:0]  deadline_new;
  logic                   any_expired;
  logic [DIV_W:0]         prescale_inc;
  logic                   prescale_wrap;

  // ---- handshake ------------------------------------------------------------

  // result register is free when empty or being taken this cycle
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_q_valid && out_free;
  // input register refills in the same cycle it drains
  assign in_stall  = rst || (in_q_valid && !out_free);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q  <= op;
      dur_q <= duration_ms;
      idx_q <= slot_index;
    end
  end

  // ---- lowest free slot -----------------------------------------------------

  always_comb begin
    found     = 1'b0;
    grant     = '0;
    grant_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && !slot_active[i]) begin
        found     = 1'b1;
        grant[i]  = 1'b1;
        grant_idx = SLOT_IDX_W'(i);
      end
    end
  end

  // ---- deadline = now + duration --------------------------------------------

  assign now_ext = {1'b0, now_ms};
  assign dur_sum = now_ext + {{(DEADLINE_W-DUR_W){dur_q[DUR_W-1]}}, dur_q};

  // a positive duration can only overflow past the clock maximum; a negative
  // one may go below zero, which is kept as a signed deadline
  assign deadline_new = (!dur_q[DUR_W-1] && dur_sum[DEADLINE_W-1]) ? DEADLINE_MAX
                                                                   : dur_sum;

  // ---- expiry check over all slots in parallel ------------------------------

  always_comb begin
    any_expired = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_active[i] && ($signed(slot_deadline[i]) < $signed(now_ext))) begin
        any_expired = 1'b1;
      end
    end
  end

  // ---- prescaler ------------------------------------------------------------

  // a divide value of zero or one wraps on every tick
  assign prescale_inc  = {1'b0, prescale_count} + {{DIV_W{1'b0}}, 1'b1};
  assign prescale_wrap = prescale_inc >= {1'b0, div_value};

  // ---- state update ---------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      div_value <= DIV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      div_value <= cycles_per_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active    <= '0;
      now_ms         <= '0;
      prescale_count <= '0;
    end else if (advance) begin
      case (op_q)
        OP_SET: begin
          slot_active <= slot_active | grant;
        end
        OP_CLEAR: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (idx_q == IDX_W'(i)) begin
              slot_active[i] <= 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (prescale_wrap) begin
            prescale_count <= '0;
            if (now_ms != NOW_MAX) begin
              now_ms <= now_ms + {{(NOW_W-1){1'b0}}, 1'b1};
            end
          end else begin
            prescale_count <= prescale_inc[DIV_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // deadline store, written only when a slot is armed
  always_ff @(posedge clk) begin
    if (advance && op_q == OP_SET) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (grant[i]) begin
          slot_deadline[i] <= deadline_new;
        end
      end
    end
  end

  // ---- result register ------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      set_ok     <= (op_q == OP_SET) && found;
      slot_given <= ((op_q == OP_SET) && found) ? GIVEN_W'(grant_idx) : '0;
      expired    <= (op_q == OP_CHECK) && any_expired;
    end
  end

endmodule

FILE: sv/wdst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdst_checker
// port-level checks of the watchdog slot table, bound to the top level
// ----------------------------------------------------------------------------
module wdst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                set_ok,
  input logic [wdst_pkg::GIVEN_W-1:0]        slot_given,
  input logic                                expired
);
  import wdst_pkg::*;

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(set_ok) && $stable(slot_given)
                               && $stable(expired))
    else $error("result changed while stalled");

  // a failed or non-set item reports slot zero
  a_given_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !set_ok |-> slot_given == '0)
    else $error("slot_given nonzero without set_ok");

  // set and check results never mix
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(set_ok && expired))
    else $error("set_ok and expired both high");

  // a fresh result is checked against an item accepted before it
  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without accepted item");

endmodule

bind watchdog_slot_table_top wdst_checker u_wdst_checker (.*);
